// File: design/echo_obstacle_hysteresis_detector_core_defines.svh
// Assertion macros used by the checker file of the obstacle detector.
// Depends on nothing; the user module must have clk_i and rst_ni in scope.
`ifndef ECHO_OBSTACLE_HYSTERESIS_DETECTOR_CORE_DEFINES_SVH
`define ECHO_OBSTACLE_HYSTERESIS_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ehd_pkg.sv
// Package of the echo obstacle detector: register codes, reset values, beat types
// and the divide-by-58 helper. Depends on nothing.
package ehd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    REG_STOP     = 3'd0,
    REG_CLEAR    = 3'd1,
    REG_CONFIRM  = 3'd2,
    REG_MAX_HOLD = 3'd3,
    REG_INTERVAL = 3'd4,
    REG_TIMEOUT  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_NO_ECHO = 2'd1,
    CAUSE_HOLD    = 2'd2
  } cause_e;

  localparam logic [10:0] StopReset     = 11'd20;
  localparam logic [10:0] ClearReset    = 11'd30;
  localparam logic [3:0]  ConfirmReset  = 4'd3;
  localparam logic [15:0] MaxHoldReset  = 16'd5000;
  localparam logic [15:0] IntervalReset = 16'd60;
  localparam logic [15:0] TimeoutReset  = 16'd30000;

  localparam logic [4:0] NoEchoExtra = 5'd2;

  // floor(x / 58) equals (x * ceil(2^22 / 58)) >> 22 for every 16-bit x.
  localparam int unsigned  Div58Shift = 22;
  localparam logic [16:0]  Div58Mul   = 17'd72316;

  typedef struct packed {
    logic [10:0] stop_distance_cm;
    logic [10:0] clear_distance_cm;
    logic [3:0]  clear_confirm_samples;
    logic [15:0] max_hold_ms;
    logic [15:0] sample_interval_ms;
    logic [15:0] echo_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] echo_us;
  } in_t;

  typedef struct packed {
    logic               sampled;
    logic signed [11:0] range_cm;
    logic               obstacle;
    logic               changed;
    logic [1:0]         force_cause;
  } out_t;

  function automatic logic [10:0] div58(input logic [15:0] echo);
    logic [32:0] prod;
    prod = {17'd0, echo} * {16'd0, Div58Mul};
    return prod[Div58Shift +: 11];
  endfunction

endpackage

// File: design/ehd_cfg_regs.sv
// Configuration register bank of the echo obstacle detector.
// Depends on ehd_pkg.
module ehd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ehd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ehd_pkg::CfgDataW-1:0] cfg_data_i,
  output ehd_pkg::cfg_t                cfg_o
);

  ehd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_distance_cm      <= ehd_pkg::StopReset;
      cfg_q.clear_distance_cm     <= ehd_pkg::ClearReset;
      cfg_q.clear_confirm_samples <= ehd_pkg::ConfirmReset;
      cfg_q.max_hold_ms           <= ehd_pkg::MaxHoldReset;
      cfg_q.sample_interval_ms    <= ehd_pkg::IntervalReset;
      cfg_q.echo_timeout_us       <= ehd_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (ehd_pkg::cfg_reg_e'(cfg_idx_i))
        ehd_pkg::REG_STOP:     cfg_q.stop_distance_cm      <= cfg_data_i[10:0];
        ehd_pkg::REG_CLEAR:    cfg_q.clear_distance_cm     <= cfg_data_i[10:0];
        ehd_pkg::REG_CONFIRM:  cfg_q.clear_confirm_samples <= cfg_data_i[3:0];
        ehd_pkg::REG_MAX_HOLD: cfg_q.max_hold_ms           <= cfg_data_i;
        ehd_pkg::REG_INTERVAL: cfg_q.sample_interval_ms    <= cfg_data_i;
        ehd_pkg::REG_TIMEOUT:  cfg_q.echo_timeout_us       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/ehd_tracker.sv
// Sample gate, distance conversion and hysteresis latch with its state registers.
// Depends on ehd_pkg.
module ehd_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  ehd_pkg::in_t  item_i,
  input  ehd_pkg::cfg_t cfg_i,
  output ehd_pkg::out_t res_o
);

  logic [31:0]        last_time_q, last_time_d;
  logic signed [11:0] last_dist_q, last_dist_d;
  logic               latch_q, latch_d;
  logic [4:0]         count_q, count_d;
  logic [31:0]        lock_q, lock_d;

  logic [31:0]   elapsed;
  logic [31:0]   held;
  logic          sample;
  logic          no_echo;
  logic [10:0]   quot;
  logic          pos;
  logic          is_stop;
  logic          is_clear;
  logic [4:0]    confirm;
  logic [4:0]    limit;
  ehd_pkg::cause_e cause;

  always_comb begin
    elapsed  = item_i.time_ms - last_time_q;
    sample   = elapsed >= {16'd0, cfg_i.sample_interval_ms};
    no_echo  = (item_i.echo_us == 16'd0) || (item_i.echo_us > cfg_i.echo_timeout_us);
    quot     = ehd_pkg::div58(item_i.echo_us);
    pos      = !no_echo && (quot != 11'd0);
    is_stop  = pos && (quot <= cfg_i.stop_distance_cm);
    is_clear = !no_echo && (quot >= cfg_i.clear_distance_cm);
    confirm  = {1'b0, cfg_i.clear_confirm_samples};
    limit    = confirm + ehd_pkg::NoEchoExtra;

    last_time_d = last_time_q;
    last_dist_d = last_dist_q;
    latch_d     = latch_q;
    count_d     = count_q;
    lock_d      = lock_q;
    cause       = ehd_pkg::CAUSE_NONE;
    held        = 32'd0;

    if (sample) begin
      last_time_d = item_i.time_ms;
      last_dist_d = no_echo ? -12'sd1 : $signed({1'b0, quot});
      if (is_stop) begin
        latch_d = 1'b1;
        count_d = 5'd0;
        lock_d  = item_i.time_ms;
      end else if (is_clear) begin
        if (count_q < confirm) count_d = count_q + 5'd1;
        if (count_d >= confirm) latch_d = 1'b0;
      end else if (pos) begin
        count_d = 5'd0;
      end else if (latch_q) begin
        if (count_q < limit) count_d = count_q + 5'd1;
        if (count_d >= limit) begin
          latch_d = 1'b0;
          cause   = ehd_pkg::CAUSE_NO_ECHO;
        end
      end
      held = item_i.time_ms - lock_d;
      if (latch_d && (lock_d != 32'd0) && (held > {16'd0, cfg_i.max_hold_ms})) begin
        latch_d = 1'b0;
        cause   = ehd_pkg::CAUSE_HOLD;
      end
    end

    res_o.sampled     = sample;
    res_o.range_cm    = last_dist_d;
    res_o.obstacle    = latch_d;
    res_o.changed     = latch_d != latch_q;
    res_o.force_cause = cause;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= 32'd0;
      last_dist_q <= 12'sd0;
      latch_q     <= 1'b0;
      count_q     <= 5'd0;
      lock_q      <= 32'd0;
    end else if (step_i) begin
      last_time_q <= last_time_d;
      last_dist_q <= last_dist_d;
      latch_q     <= latch_d;
      count_q     <= count_d;
      lock_q      <= lock_d;
    end
  end

endmodule

// File: design/echo_obstacle_hysteresis_detector_core.sv
// Top level of the echo obstacle detector: input register, tracker, result register.
// Depends on ehd_pkg, ehd_cfg_regs and ehd_tracker.
//
//   channel | direction | handshake              | payload
//   cfg     | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//   in      | in        | in_valid_i / in_stall_o | in_data_i  (ehd_pkg::in_t)
//   out     | out       | out_valid_o / out_stall_i | out_data_o (ehd_pkg::out_t)
//
// One beat enters per cycle and its result passes the input register, the tracker
// and the result register. Throughput is one beat per cycle when out_stall_i is low.
// Reset restores the register defaults and clears the detector state.
// A stall on the output holds the result and backs up into in_stall_o.
module echo_obstacle_hysteresis_detector_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ehd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ehd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ehd_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ehd_pkg::out_t                out_data_o
);

  ehd_pkg::cfg_t cfg;
  ehd_pkg::out_t res;

  logic          in_v_q, in_v_d;
  ehd_pkg::in_t  in_q;
  logic          out_v_q, out_v_d;
  ehd_pkg::out_t out_q;
  logic          advance;
  logic          in_acc;

  ehd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ehd_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance && in_v_q),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    advance    = !out_v_q || !out_stall_i;
    in_stall_o = in_v_q && !advance;
    in_acc     = in_valid_i && !in_stall_o;
    in_v_d     = in_acc ? 1'b1 : (advance ? 1'b0 : in_v_q);
    out_v_d    = advance ? in_v_q : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_data_i;
    if (advance && in_v_q) out_q <= res;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: design/ehd_checker.sv
// Port-level checker of the echo obstacle detector and its bind to the top level.
// Depends on ehd_pkg and echo_obstacle_hysteresis_detector_core_defines.svh.
`include "echo_obstacle_hysteresis_detector_core_defines.svh"

module ehd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input ehd_pkg::in_t                 in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input ehd_pkg::out_t                out_data_o
);

  `EHD_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_data_i), "stalled input beat changed")
  `EHD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result beat changed")
  `EHD_ASSERT_NOW(a_force_clears, out_valid_o && (out_data_o.force_cause != ehd_pkg::CAUSE_NONE), out_data_o.sampled && out_data_o.changed && !out_data_o.obstacle, "forced clear without a falling latch")
  `EHD_ASSERT_NOW(a_skip_quiet, out_valid_o && !out_data_o.sampled, !out_data_o.changed && (out_data_o.force_cause == ehd_pkg::CAUSE_NONE), "skipped beat changed the latch")
  `EHD_ASSERT_NOW(a_cause_code, out_valid_o, out_data_o.force_cause <= ehd_pkg::CAUSE_HOLD, "undefined force cause")

endmodule

bind echo_obstacle_hysteresis_detector_core ehd_checker u_ehd_checker (.*);

// File: tb/sv/tb_echo_obstacle_hysteresis_detector_core.sv
// Self-checking bench for the echo obstacle detector: directed beats, then randomized
// phases under several register settings, checked against an in-bench latch tracker.
// Depends on ehd_pkg and echo_obstacle_hysteresis_detector_core.
module tb_echo_obstacle_hysteresis_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned PhaseCount    = 10;
  localparam int unsigned BeatsPerPhase = 36;
  localparam int unsigned MaxReports    = 40;
  localparam int unsigned UsPerCm       = 58;
  localparam int unsigned MaxCm         = 1129;
  localparam int unsigned EchoMax       = 65535;
  localparam logic [ehd_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  typedef enum int unsigned {
    DRIVE_APPROACH, DRIVE_RECEDE, DRIVE_LOST, DRIVE_EDGES, DRIVE_NOISE
  } drive_e;

  typedef enum int unsigned {
    ECHO_NEAR, ECHO_FAR, ECHO_MID, ECHO_NONE, ECHO_SHORT, ECHO_LATE, ECHO_ANY, ECHO_EDGE
  } echo_kind_e;

  typedef enum int unsigned {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_e;

  typedef struct packed {
    ehd_pkg::in_t  beat;
    logic          typed;
    ehd_pkg::out_t want;
  } row_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [ehd_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [ehd_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  ehd_pkg::in_t                 in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  ehd_pkg::out_t                out_data_o;

  ehd_pkg::cfg_t      shadow_cfg;
  logic [31:0]        seen_time;
  logic signed [11:0] seen_dist;
  logic               blocked;
  logic [4:0]         clear_run;
  logic [31:0]        locked_at;

  ehd_pkg::out_t pending_results[$];
  row_t          plan[$];
  logic [31:0] clock_ms    = '0;
  int unsigned burst_left  = 0;
  logic        steady      = 1'b0;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  stall_e      stall_mode  = STALL_NONE;
  int unsigned stall_left  = 0;

  echo_obstacle_hysteresis_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic ehd_pkg::out_t track_obstacle(input ehd_pkg::in_t beat);
    ehd_pkg::out_t   r;
    logic [31:0]     since;
    logic [31:0]     held;
    logic [4:0]      confirm;
    logic [4:0]      limit;
    int              cm;
    logic            prev;
    ehd_pkg::cause_e cause;
    prev    = blocked;
    cause   = ehd_pkg::CAUSE_NONE;
    since   = beat.time_ms - seen_time;
    confirm = {1'b0, shadow_cfg.clear_confirm_samples};
    limit   = confirm + ehd_pkg::NoEchoExtra;
    r.sampled = 1'b0;
    if (since >= {16'd0, shadow_cfg.sample_interval_ms}) begin
      if (beat.echo_us == 16'd0 || beat.echo_us > shadow_cfg.echo_timeout_us) begin
        cm = -1;
      end else begin
        cm = int'(beat.echo_us) / UsPerCm;
      end
      r.sampled = 1'b1;
      seen_time = beat.time_ms;
      seen_dist = cm[11:0];
      if (cm > 0 && cm <= int'(shadow_cfg.stop_distance_cm)) begin
        blocked   = 1'b1;
        clear_run = '0;
        locked_at = beat.time_ms;
      end else if (cm >= int'(shadow_cfg.clear_distance_cm)) begin
        if (clear_run < confirm) clear_run = clear_run + 5'd1;
        if (clear_run >= confirm) blocked = 1'b0;
      end else if (cm > 0) begin
        clear_run = '0;
      end else if (blocked) begin
        if (clear_run < limit) clear_run = clear_run + 5'd1;
        if (clear_run >= limit) begin
          blocked = 1'b0;
          cause   = ehd_pkg::CAUSE_NO_ECHO;
        end
      end
      held = beat.time_ms - locked_at;
      if (blocked && locked_at != '0 && held > {16'd0, shadow_cfg.max_hold_ms}) begin
        blocked = 1'b0;
        cause   = ehd_pkg::CAUSE_HOLD;
      end
    end
    r.range_cm    = seen_dist;
    r.obstacle    = blocked;
    r.changed     = (blocked != prev);
    r.force_cause = cause;
    return r;
  endfunction

  function automatic row_t step_row(input ehd_pkg::in_t beat, input logic typed,
                                    input ehd_pkg::out_t want);
    row_t r;
    r.beat  = beat;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic logic [15:0] pick_echo(input drive_e mode);
    int unsigned stop, clr, tmo, lo, hi, e;
    echo_kind_e  kind;
    stop = shadow_cfg.stop_distance_cm;
    clr  = shadow_cfg.clear_distance_cm;
    tmo  = shadow_cfg.echo_timeout_us;
    case (mode)
      DRIVE_APPROACH: kind = ($urandom_range(0, 3) == 0) ? ECHO_MID : ECHO_NEAR;
      DRIVE_RECEDE:   kind = ($urandom_range(0, 3) == 0) ? ECHO_MID : ECHO_FAR;
      DRIVE_LOST:     kind = echo_kind_e'($urandom_range(ECHO_NONE, ECHO_LATE));
      DRIVE_EDGES:    kind = ECHO_EDGE;
      default:        kind = echo_kind_e'($urandom_range(ECHO_NEAR, ECHO_EDGE));
    endcase
    lo = 1;
    hi = MaxCm;
    case (kind)
      ECHO_NEAR: hi = (stop == 0) ? 1 : ((stop < MaxCm) ? stop : MaxCm);
      ECHO_FAR:  lo = (clr < MaxCm) ? clr : MaxCm;
      ECHO_MID: begin
        if (clr > stop + 1 && stop < MaxCm) begin
          lo = stop + 1;
          hi = (clr - 1 < MaxCm) ? clr - 1 : MaxCm;
        end
      end
      default: ;
    endcase
    e = $urandom_range(lo, hi) * UsPerCm + $urandom_range(0, UsPerCm - 1);
    case (kind)
      ECHO_NONE:  e = 0;
      ECHO_SHORT: e = $urandom_range(1, UsPerCm - 1);
      ECHO_LATE:  e = (tmo < EchoMax) ? $urandom_range(tmo + 1, EchoMax) : 0;
      ECHO_ANY:   e = $urandom_range(0, EchoMax);
      ECHO_EDGE: begin
        case ($urandom_range(0, 5))
          0:       e = stop * UsPerCm;
          1:       e = stop * UsPerCm + UsPerCm - 1;
          2:       e = clr * UsPerCm;
          3:       e = (clr == 0) ? EchoMax : clr * UsPerCm - 1;
          4:       e = tmo;
          default: e = tmo + 1;
        endcase
      end
      default: ;
    endcase
    if (e > EchoMax) e = EchoMax;
    return e[15:0];
  endfunction

  function automatic logic [31:0] next_gap_ms();
    logic [31:0] itv;
    logic [31:0] hold;
    itv  = {16'd0, shadow_cfg.sample_interval_ms};
    hold = {16'd0, shadow_cfg.max_hold_ms};
    case ($urandom_range(0, 15))
      0:       return $urandom;
      1, 2:    return $urandom_range(0, itv);
      3:       return itv;
      4:       return hold + $urandom_range(0, 1);
      default: return itv + $urandom_range(0, 120);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MaxReports) $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic send_beat(input ehd_pkg::in_t beat, input logic typed,
                           input ehd_pkg::out_t want, output logic took);
    ehd_pkg::out_t pred;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = track_obstacle(beat);
    pending_results.push_back(typed ? want : pred);
    took = pred.sampled;
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = steady ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        in_data_i  <= {$urandom, 16'($urandom)};
      end
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ehd_pkg::CfgIdxW-1:0] idx,
                           input logic [ehd_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      ehd_pkg::REG_STOP:     shadow_cfg.stop_distance_cm      = value[10:0];
      ehd_pkg::REG_CLEAR:    shadow_cfg.clear_distance_cm     = value[10:0];
      ehd_pkg::REG_CONFIRM:  shadow_cfg.clear_confirm_samples = value[3:0];
      ehd_pkg::REG_MAX_HOLD: shadow_cfg.max_hold_ms           = value;
      ehd_pkg::REG_INTERVAL: shadow_cfg.sample_interval_ms    = value;
      ehd_pkg::REG_TIMEOUT:  shadow_cfg.echo_timeout_us       = value;
      default: ;
    endcase
  endtask

  task automatic load_config(input ehd_pkg::cfg_t s);
    ehd_pkg::cfg_reg_e idx;
    logic [15:0]       value;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        ehd_pkg::REG_STOP:     value = {5'($urandom), s.stop_distance_cm};
        ehd_pkg::REG_CLEAR:    value = {5'($urandom), s.clear_distance_cm};
        ehd_pkg::REG_CONFIRM:  value = {12'($urandom), s.clear_confirm_samples};
        ehd_pkg::REG_MAX_HOLD: value = s.max_hold_ms;
        ehd_pkg::REG_INTERVAL: value = s.sample_interval_ms;
        default:               value = s.echo_timeout_us;
      endcase
      write_reg(idx, value);
      idx = idx.next();
    end
    write_reg(RegUnused, 16'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned  took_n;
    int unsigned  mode_left;
    drive_e       mode;
    ehd_pkg::in_t beat;
    logic         took;
    took_n    = 0;
    mode_left = 0;
    mode      = DRIVE_NOISE;
    while (took_n < target) begin
      if (mode_left == 0) begin
        mode      = drive_e'($urandom_range(DRIVE_APPROACH, DRIVE_NOISE));
        mode_left = $urandom_range(1, 10);
      end
      mode_left--;
      clock_ms     = clock_ms + next_gap_ms();
      beat.time_ms = clock_ms;
      beat.echo_us = pick_echo(mode);
      send_beat(beat, 1'b0, '0, took);
      if (took) took_n++;
      pace();
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_e'($urandom_range(STALL_NONE, STALL_PERIODIC));
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_left % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin : check_results
    ehd_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing pending", out_data_o));
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.sampled !== want.sampled)
          report_mismatch($sformatf("sampled %b, want %b", out_data_o.sampled, want.sampled));
        if (out_data_o.range_cm !== want.range_cm)
          report_mismatch($sformatf("range_cm %0d, want %0d",
                                    out_data_o.range_cm, want.range_cm));
        if (out_data_o.obstacle !== want.obstacle)
          report_mismatch($sformatf("obstacle %b, want %b", out_data_o.obstacle,
                                    want.obstacle));
        if (out_data_o.changed !== want.changed)
          report_mismatch($sformatf("changed %b, want %b", out_data_o.changed, want.changed));
        if (out_data_o.force_cause !== want.force_cause)
          report_mismatch($sformatf("force_cause %0d, want %0d", out_data_o.force_cause,
                                    want.force_cause));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic          took;
    ehd_pkg::cfg_t setting;
    shadow_cfg = {ehd_pkg::StopReset, ehd_pkg::ClearReset, ehd_pkg::ConfirmReset,
                  ehd_pkg::MaxHoldReset, ehd_pkg::IntervalReset, ehd_pkg::TimeoutReset};
    seen_time  = '0;
    seen_dist  = '0;
    blocked    = 1'b0;
    clear_run  = '0;
    locked_at  = '0;

    // The first beat lands inside the interval of the reset sample time.
    plan.push_back(step_row({32'd0, 16'd1160}, 1'b1,
                            {1'b0, 12'sd0, 1'b0, 1'b0, ehd_pkg::CAUSE_NONE}));
    plan.push_back(step_row({32'd60, 16'd1160}, 1'b1,
                            {1'b1, 12'sd20, 1'b1, 1'b1, ehd_pkg::CAUSE_NONE}));
    plan.push_back(step_row({32'd100, 16'd0}, 1'b1,
                            {1'b0, 12'sd20, 1'b1, 1'b0, ehd_pkg::CAUSE_NONE}));
    plan.push_back(step_row({32'd120, 16'd0}, 1'b0, '0));
    plan.push_back(step_row({32'd180, 16'hFFFF}, 1'b0, '0));
    plan.push_back(step_row({32'd240, 16'd57}, 1'b0, '0));
    plan.push_back(step_row({32'd300, 16'd30001}, 1'b0, '0));
    plan.push_back(step_row({32'd360, 16'd30000}, 1'b0, '0));
    plan.push_back(step_row({32'd420, 16'd1218}, 1'b0, '0));
    plan.push_back(step_row({32'd480, 16'd1160}, 1'b0, '0));
    plan.push_back(step_row({32'd540, 16'd0}, 1'b0, '0));
    plan.push_back(step_row({32'd600, 16'd0}, 1'b0, '0));
    plan.push_back(step_row({32'd660, 16'd0}, 1'b0, '0));
    plan.push_back(step_row({32'd720, 16'd0}, 1'b0, '0));
    plan.push_back(step_row({32'd780, 16'd0}, 1'b1,
                            {1'b1, 12'hFFF, 1'b0, 1'b1, ehd_pkg::CAUSE_NO_ECHO}));
    plan.push_back(step_row({32'd840, 16'd1740}, 1'b0, '0));
    plan.push_back(step_row({32'd900, 16'd1159}, 1'b0, '0));
    plan.push_back(step_row({32'd6000, 16'd1740}, 1'b1,
                            {1'b1, 12'sd30, 1'b0, 1'b1, ehd_pkg::CAUSE_HOLD}));
    plan.push_back(step_row({32'hFFFF_FFF0, 16'd58}, 1'b1,
                            {1'b1, 12'sd1, 1'b1, 1'b1, ehd_pkg::CAUSE_NONE}));
    plan.push_back(step_row({32'h0000_0030, 16'd2900}, 1'b0, '0));
    plan.push_back(step_row({32'h0000_0000, 16'd1160}, 1'b0, '0));
    plan.push_back(step_row({32'h0001_0000, 16'd1740}, 1'b0, '0));
    plan.push_back(step_row({32'h8000_0000, 16'hFFFF}, 1'b0, '0));
    plan.push_back(step_row({32'hFFFF_FFFF, 16'h8000}, 1'b0, '0));
    plan.push_back(step_row({32'h0000_003B, 16'd1218}, 1'b0, '0));

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      send_beat(plan[i].beat, plan[i].typed, plan[i].want, took);
      pace();
    end
    clock_ms = 32'h0000_003B;
    settle();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: setting = {11'd1, 11'd1, 4'd1, 16'd0, 16'd0, 16'd1};
        1: setting = '0;
        2: setting = '1;
        3: setting = {ehd_pkg::StopReset, 11'd0, 4'd0, 16'hFFFF, 16'd0, 16'hFFFF};
        4: setting = {ehd_pkg::StopReset, ehd_pkg::ClearReset, ehd_pkg::ConfirmReset,
                      ehd_pkg::MaxHoldReset, ehd_pkg::IntervalReset, ehd_pkg::TimeoutReset};
        default: begin
          setting.stop_distance_cm      = 11'($urandom_range(1, 60));
          setting.clear_distance_cm     = setting.stop_distance_cm + 11'($urandom_range(0, 40));
          setting.clear_confirm_samples = 4'($urandom_range(0, 15));
          setting.max_hold_ms           = 16'($urandom_range(100, 3000));
          setting.sample_interval_ms    = 16'($urandom_range(0, 100));
          setting.echo_timeout_us       = 16'($urandom_range(2000, 40000));
          if ($urandom_range(0, 3) == 0) setting.clear_distance_cm = 11'($urandom);
          if ($urandom_range(0, 3) == 0) setting.max_hold_ms = 16'($urandom);
          if ($urandom_range(0, 3) == 0) setting.echo_timeout_us = 16'($urandom);
        end
      endcase
      steady = ($urandom_range(0, 3) == 0);
      load_config(setting);
      run_phase(BeatsPerPhase);
      settle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
